>>> src/ctc_pkg.sv
// ----------------------------------------------------------------------------
// Cook timer controller package
// Shared types, command codes, preset values and digit helpers.
// ----------------------------------------------------------------------------
package ctc_pkg;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_DONE  = 3'd1,
    PH_TIME  = 3'd2,
    PH_POWER = 3'd3,
    PH_RUN   = 3'd4
  } phase_t;

  typedef enum logic [3:0] {
    OP_TICK,
    OP_TIME,
    OP_POWER,
    OP_PRESS,
    OP_REHEAT,
    OP_DEFROST,
    OP_POPCORN,
    OP_POTATO,
    OP_DATA
  } op_t;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_TIME,
    ACT_POWER,
    ACT_ARM,
    ACT_TO_TIME,
    ACT_FINISH,
    ACT_SILENCE,
    ACT_START,
    ACT_DECR,
    ACT_HOLD,
    ACT_DROP
  } act_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } item_t;

  localparam logic [7:0] CMD_TIME    = 8'h80;
  localparam logic [7:0] CMD_POWER   = 8'hC0;
  localparam logic [7:0] CMD_PRESS   = 8'hFF;
  localparam logic [7:0] CMD_REHEAT  = 8'hF8;
  localparam logic [7:0] CMD_DEFROST = 8'hF9;
  localparam logic [7:0] CMD_POPCORN = 8'hFA;
  localparam logic [7:0] CMD_POTATO  = 8'hFB;

  localparam logic [2:0] MIN_FORM = 3'b101;

  localparam int COUNT_W = 12;
  localparam int POWER_W = 4;
  localparam int BAR_W   = 10;

  localparam logic [COUNT_W-1:0] REHEAT_SECS  = 12'd105;
  localparam logic [COUNT_W-1:0] DEFROST_SECS = 12'd300;
  localparam logic [COUNT_W-1:0] POPCORN_SECS = 12'd150;
  localparam logic [COUNT_W-1:0] POTATO_SECS  = 12'd240;
  localparam logic [POWER_W-1:0] REHEAT_PWR   = 4'd6;
  localparam logic [POWER_W-1:0] DEFROST_PWR  = 4'd3;
  localparam logic [POWER_W-1:0] POPCORN_PWR  = 4'd8;
  localparam logic [POWER_W-1:0] POTATO_PWR   = 4'd9;
  localparam logic [POWER_W-1:0] FULL_PWR     = 4'd10;

  // Minutes are count * MIN_RECIP >> MIN_SHIFT, exact for counts below 4096.
  localparam logic [12:0] MIN_RECIP = 13'd4370;
  localparam int          MIN_SHIFT = 18;

  localparam int QUEUE_DEPTH = 2;

  function automatic logic [2:0] tens_of(input logic [5:0] x);
    logic [2:0] t;
    priority if (x >= 6'd50) t = 3'd5;
    else if (x >= 6'd40) t = 3'd4;
    else if (x >= 6'd30) t = 3'd3;
    else if (x >= 6'd20) t = 3'd2;
    else if (x >= 6'd10) t = 3'd1;
    else t = 3'd0;
    return t;
  endfunction

  function automatic logic [3:0] ones_of(input logic [5:0] x);
    logic [2:0] t;
    logic [5:0] r;
    t = tens_of(x);
    r = x - {t, 3'b000} - 6'({t, 1'b0});
    return r[3:0];
  endfunction

endpackage

>>> src/ctc_in_if.sv
// ----------------------------------------------------------------------------
// Cook timer input channel
// Carries one received byte or one-second tick per item.
// ----------------------------------------------------------------------------
interface ctc_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] rx_byte;

  modport source (output valid, output req_type, output rx_byte, input ready);
  modport sink (input valid, input req_type, input rx_byte, output ready);
endinterface

>>> src/ctc_out_if.sv
// ----------------------------------------------------------------------------
// Cook timer output channel
// Carries the phase, remaining time, digits, power bar and lamp per item.
// ----------------------------------------------------------------------------
interface ctc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic [11:0] seconds_left;
  logic [3:0] power_level;
  logic [9:0] bar_pattern;
  logic       lamp_on;
  logic       alarm_on;
  logic [1:0] minutes_tens;
  logic [3:0] minutes_ones;
  logic [2:0] seconds_tens;
  logic [3:0] seconds_ones;

  modport source (
    output valid, output mode, output seconds_left, output power_level,
    output bar_pattern, output lamp_on, output alarm_on, output minutes_tens,
    output minutes_ones, output seconds_tens, output seconds_ones, input ready
  );
  modport sink (
    input valid, input mode, input seconds_left, input power_level,
    input bar_pattern, input lamp_on, input alarm_on, input minutes_tens,
    input minutes_ones, input seconds_tens, input seconds_ones, output ready
  );
endinterface

>>> src/ctc_front.sv
// ----------------------------------------------------------------------------
// Cook timer front end
// Accepts input items and classifies each into an operation code.
// ----------------------------------------------------------------------------
module ctc_front (
  ctc_in_if.sink          in_ch,
  output logic            push_valid,
  input  logic            push_ready,
  output ctc_pkg::item_t  push_item
);

  always_comb begin
    push_item.data = in_ch.rx_byte;
    if (in_ch.req_type) begin
      push_item.op = ctc_pkg::OP_TICK;
    end else begin
      unique case (in_ch.rx_byte)
        ctc_pkg::CMD_TIME:    push_item.op = ctc_pkg::OP_TIME;
        ctc_pkg::CMD_POWER:   push_item.op = ctc_pkg::OP_POWER;
        ctc_pkg::CMD_PRESS:   push_item.op = ctc_pkg::OP_PRESS;
        ctc_pkg::CMD_REHEAT:  push_item.op = ctc_pkg::OP_REHEAT;
        ctc_pkg::CMD_DEFROST: push_item.op = ctc_pkg::OP_DEFROST;
        ctc_pkg::CMD_POPCORN: push_item.op = ctc_pkg::OP_POPCORN;
        ctc_pkg::CMD_POTATO:  push_item.op = ctc_pkg::OP_POTATO;
        default:              push_item.op = ctc_pkg::OP_DATA;
      endcase
    end
  end

  assign push_valid  = in_ch.valid;
  assign in_ch.ready = push_ready;

endmodule

>>> src/ctc_queue.sv
// ----------------------------------------------------------------------------
// Cook timer item queue
// Two-entry queue of classified items between the front and back ends.
// ----------------------------------------------------------------------------
module ctc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  ctc_pkg::item_t push_item,
  output logic           pop_valid,
  input  logic           pop_ready,
  output ctc_pkg::item_t pop_item
);

  localparam int PTR_W = $clog2(ctc_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(ctc_pkg::QUEUE_DEPTH + 1);

  ctc_pkg::item_t entries [ctc_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic push;
  logic pop;

  assign push_ready = count != CNT_W'(ctc_pkg::QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(ctc_pkg::QUEUE_DEPTH))
    else $error("Queue holds more items than it has entries.");

  a_pop_refill: assert property (@(posedge clk) disable iff (rst)
    (count == CNT_W'(ctc_pkg::QUEUE_DEPTH) && !pop_ready) |=> !push_ready)
    else $error("Full queue accepted an item without a pop.");

endmodule

>>> src/ctc_back.sv
// ----------------------------------------------------------------------------
// Cook timer back end
// Applies each item to the timer state and forms the mm:ss digits of the
// result in a short stalling pipeline ahead of the output register.
// ----------------------------------------------------------------------------
module ctc_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  output logic           q_ready,
  input  ctc_pkg::item_t q_item,
  ctc_out_if.source      out_ch
);

  localparam int CW = ctc_pkg::COUNT_W;
  localparam int PW = ctc_pkg::POWER_W;

  ctc_pkg::phase_t phase;
  ctc_pkg::phase_t phase_next;
  logic [CW-1:0]   count_left;
  logic [CW-1:0]   count_left_next;
  logic [PW-1:0]   drive_level;
  logic [PW-1:0]   drive_level_next;
  logic [7:0]      first_byte;
  logic [7:0]      first_byte_next;
  logic            byte_seen;
  logic            byte_seen_next;
  logic            armed;
  logic            armed_next;

  ctc_pkg::act_t   act;
  logic [CW-1:0]   run_secs;
  logic [PW-1:0]   run_pwr;
  logic [CW-1:0]   entry_secs;
  logic            pop;

  logic            v1;
  ctc_pkg::phase_t p1;
  logic [CW-1:0]   c1;
  logic [PW-1:0]   w1;
  logic            v2;
  ctc_pkg::phase_t p2;
  logic [CW-1:0]   c2;
  logic [PW-1:0]   w2;
  logic [5:0]      m2;
  logic            v3;
  logic            ready1;
  logic            ready2;
  logic            ready3;
  logic [24:0]     min_prod;
  logic [CW-1:0]   sec_diff;
  logic [5:0]      secs2;
  logic [9:0]      bar2;
  logic [2:0]      mt2;

  assign pop = q_valid && q_ready;
  assign entry_secs = {1'b0, first_byte[4:0], 6'b000000}
                    - {5'b00000, first_byte[4:0], 2'b00}
                    + {4'b0000, q_item.data};

  always_comb begin
    act      = ctc_pkg::ACT_NONE;
    run_secs = '0;
    run_pwr  = '0;
    if (pop) begin
      unique case (q_item.op)
        ctc_pkg::OP_TICK: begin
          if (phase == ctc_pkg::PH_RUN) begin
            act = (count_left <= CW'(1)) ? ctc_pkg::ACT_FINISH : ctc_pkg::ACT_DECR;
          end
        end
        ctc_pkg::OP_TIME: begin
          if (phase != ctc_pkg::PH_RUN) begin
            act = ctc_pkg::ACT_TIME;
          end
        end
        ctc_pkg::OP_POWER: begin
          if (phase != ctc_pkg::PH_RUN) begin
            act = ctc_pkg::ACT_POWER;
          end
        end
        ctc_pkg::OP_PRESS: begin
          unique case (phase)
            ctc_pkg::PH_TIME:  act = ctc_pkg::ACT_ARM;
            ctc_pkg::PH_POWER: act = ctc_pkg::ACT_TO_TIME;
            ctc_pkg::PH_RUN:   act = ctc_pkg::ACT_FINISH;
            ctc_pkg::PH_DONE:  act = ctc_pkg::ACT_SILENCE;
            default:           act = ctc_pkg::ACT_NONE;
          endcase
        end
        ctc_pkg::OP_REHEAT: begin
          act      = ctc_pkg::ACT_START;
          run_secs = ctc_pkg::REHEAT_SECS;
          run_pwr  = ctc_pkg::REHEAT_PWR;
        end
        ctc_pkg::OP_DEFROST: begin
          act      = ctc_pkg::ACT_START;
          run_secs = ctc_pkg::DEFROST_SECS;
          run_pwr  = ctc_pkg::DEFROST_PWR;
        end
        ctc_pkg::OP_POPCORN: begin
          act      = ctc_pkg::ACT_START;
          run_secs = ctc_pkg::POPCORN_SECS;
          run_pwr  = ctc_pkg::POPCORN_PWR;
        end
        ctc_pkg::OP_POTATO: begin
          act      = ctc_pkg::ACT_START;
          run_secs = ctc_pkg::POTATO_SECS;
          run_pwr  = ctc_pkg::POTATO_PWR;
        end
        ctc_pkg::OP_DATA: begin
          if (phase == ctc_pkg::PH_TIME && armed) begin
            if (!byte_seen) begin
              act = ctc_pkg::ACT_HOLD;
            end else if (first_byte[7:5] == ctc_pkg::MIN_FORM) begin
              act      = ctc_pkg::ACT_START;
              run_secs = entry_secs;
              run_pwr  = ctc_pkg::FULL_PWR;
            end else begin
              act = ctc_pkg::ACT_DROP;
            end
          end
        end
        default: act = ctc_pkg::ACT_NONE;
      endcase
      if (act == ctc_pkg::ACT_START && run_secs == '0) begin
        act = ctc_pkg::ACT_FINISH;
      end
    end
  end

  always_comb begin
    unique case (act)
      ctc_pkg::ACT_TIME,
      ctc_pkg::ACT_TO_TIME: phase_next = ctc_pkg::PH_TIME;
      ctc_pkg::ACT_POWER:   phase_next = ctc_pkg::PH_POWER;
      ctc_pkg::ACT_FINISH:  phase_next = ctc_pkg::PH_DONE;
      ctc_pkg::ACT_SILENCE: phase_next = ctc_pkg::PH_IDLE;
      ctc_pkg::ACT_START:   phase_next = ctc_pkg::PH_RUN;
      default:              phase_next = phase;
    endcase
  end

  always_comb begin
    count_left_next  = count_left;
    drive_level_next = drive_level;
    first_byte_next  = first_byte;
    byte_seen_next   = byte_seen;
    armed_next       = armed;
    unique case (act)
      ctc_pkg::ACT_TIME,
      ctc_pkg::ACT_POWER: begin
        first_byte_next  = '0;
        byte_seen_next   = 1'b0;
        armed_next       = 1'b0;
        drive_level_next = '0;
      end
      ctc_pkg::ACT_ARM: begin
        first_byte_next = '0;
        byte_seen_next  = 1'b0;
        armed_next      = 1'b1;
      end
      ctc_pkg::ACT_TO_TIME,
      ctc_pkg::ACT_SILENCE: begin
        first_byte_next = '0;
        byte_seen_next  = 1'b0;
        armed_next      = 1'b0;
      end
      ctc_pkg::ACT_FINISH: begin
        first_byte_next  = '0;
        byte_seen_next   = 1'b0;
        armed_next       = 1'b0;
        count_left_next  = '0;
        drive_level_next = '0;
      end
      ctc_pkg::ACT_START: begin
        first_byte_next  = '0;
        byte_seen_next   = 1'b0;
        armed_next       = 1'b0;
        count_left_next  = run_secs;
        drive_level_next = run_pwr;
      end
      ctc_pkg::ACT_DECR: count_left_next = count_left - 1'b1;
      ctc_pkg::ACT_HOLD: begin
        first_byte_next = q_item.data;
        byte_seen_next  = 1'b1;
      end
      ctc_pkg::ACT_DROP: begin
        first_byte_next = '0;
        byte_seen_next  = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= ctc_pkg::PH_IDLE;
      count_left  <= '0;
      drive_level <= '0;
      first_byte  <= '0;
      byte_seen   <= 1'b0;
      armed       <= 1'b0;
    end else begin
      phase       <= phase_next;
      count_left  <= count_left_next;
      drive_level <= drive_level_next;
      first_byte  <= first_byte_next;
      byte_seen   <= byte_seen_next;
      armed       <= armed_next;
    end
  end

  assign ready3  = out_ch.ready || !v3;
  assign ready2  = ready3 || !v2;
  assign ready1  = ready2 || !v1;
  assign q_ready = ready1;

  assign min_prod = 25'(c1) * 25'(ctc_pkg::MIN_RECIP);
  assign sec_diff = c2 - {m2, 6'b000000} + {4'b0000, m2, 2'b00};
  assign secs2    = sec_diff[5:0];
  assign mt2      = ctc_pkg::tens_of(m2);

  always_comb begin
    for (int i = 0; i < ctc_pkg::BAR_W; i++) begin
      bar2[i] = w2 > PW'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (ready1) begin
        v1 <= pop;
      end
      if (ready2) begin
        v2 <= v1;
      end
      if (ready3) begin
        v3 <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready1) begin
      p1 <= phase_next;
      c1 <= count_left_next;
      w1 <= drive_level_next;
    end
    if (ready2) begin
      p2 <= p1;
      c2 <= c1;
      w2 <= w1;
      m2 <= min_prod[ctc_pkg::MIN_SHIFT+5:ctc_pkg::MIN_SHIFT];
    end
    if (ready3) begin
      out_ch.mode         <= p2;
      out_ch.seconds_left <= c2;
      out_ch.power_level  <= w2;
      out_ch.bar_pattern  <= bar2;
      out_ch.lamp_on      <= p2 == ctc_pkg::PH_RUN;
      out_ch.alarm_on     <= p2 == ctc_pkg::PH_DONE;
      out_ch.minutes_tens <= mt2[1:0];
      out_ch.minutes_ones <= ctc_pkg::ones_of(m2);
      out_ch.seconds_tens <= ctc_pkg::tens_of(secs2);
      out_ch.seconds_ones <= ctc_pkg::ones_of(secs2);
    end
  end

  assign out_ch.valid = v3;

  a_run_has_time: assert property (@(posedge clk) disable iff (rst)
    phase == ctc_pkg::PH_RUN |-> count_left != '0)
    else $error("Running with no time left.");

  a_power_off_when_idle: assert property (@(posedge clk) disable iff (rst)
    phase != ctc_pkg::PH_RUN |-> drive_level == '0)
    else $error("Heating power left on outside a run.");

  a_held_byte_armed: assert property (@(posedge clk) disable iff (rst)
    byte_seen |-> (armed && phase == ctc_pkg::PH_TIME))
    else $error("Minutes byte held outside armed time entry.");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (v3 && !out_ch.ready) |=> (v3 && $stable(out_ch.seconds_left)))
    else $error("Stalled result changed before it was taken.");

endmodule

>>> src/cook_timer_controller_top.sv
// ----------------------------------------------------------------------------
// Cook timer controller
// Oven countdown: command bytes and one-second ticks in, display state out.
// Throughput: one item per cycle unless the output stalls; the state update
// for an item is done in the cycle it leaves the two-entry queue, and the
// digit split takes two further pipeline stages.
// Reset: synchronous; the timer returns to idle with no time and no power,
// and the queue and pipeline are emptied.
// ----------------------------------------------------------------------------
module cook_timer_controller_top (
  input  logic      clk,
  input  logic      rst,
  ctc_in_if.sink    in_ch,
  ctc_out_if.source out_ch
);

  logic           push_valid;
  logic           push_ready;
  ctc_pkg::item_t push_item;
  logic           pop_valid;
  logic           pop_ready;
  ctc_pkg::item_t pop_item;

  ctc_front u_front (
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  ctc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  ctc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (pop_valid),
    .q_ready (pop_ready),
    .q_item  (pop_item),
    .out_ch  (out_ch)
  );

endmodule
